[rtl/hcbp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared constants and request codes for the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  // Table geometry and code length limit
  localparam int unsigned MAX_CODE_LEN = 32;
  localparam int unsigned SYMBOLS      = 256;
  localparam int unsigned ADDR_W       = $clog2(SYMBOLS);
  localparam int unsigned CODE_W       = 32;

  localparam logic [5:0] LEN_LIMIT =
    6'((MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W);
  localparam logic [8:0] SYM_END = 9'(SYMBOLS);

  // Accumulator: up to seven pending bits plus one full code
  localparam int unsigned ACC_W = CODE_W + 7;

  // Request codes
  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FINISH = 2'd2
  } req_e;

  // Result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

endpackage
`default_nettype wire

[rtl/hcbp_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hcbp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/huffman_code_bit_packer_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// Huffman code table plus MSB-first bit packer with end-of-stream padding.
// ----------------------------------------------------------------------------
// A table load is written as it is accepted and the block stays idle. An
// encode producing n output bytes (n = 0..4) is accepted, does the table read
// and merge, sends each byte through the shared byte-extraction shifter and
// parks the leftover bits. A finish emits its one or two bytes the same way.
// An error result leaves from the error state, reached on accept (load) or
// after the table read (encode). Bytes leave through a single output register,
// so a stalled output holds the sequencer in its emit state. The code and
// length tables are RAMs with a registered read; the length table has a valid
// bit per entry, cleared at reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [7:0]  symbol_i,
  input  wire logic [31:0] code_bits_i,
  input  wire logic [5:0]  code_length_i,
  // Result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             is_last_o,
  output logic             status_o
);

  import hcbp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EMIT,
    ST_ERR
  } st_e;

  st_e              st_q;
  logic [ACC_W-1:0] acc_q;
  logic [5:0]       total_q;
  logic             flag_q;
  logic [7:0]       sym_q;
  logic [6:0]       pend_q;
  logic [2:0]       cnt_q;
  logic             vld_q [SYMBOLS];
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_last_q;
  logic             out_status_q;

  logic              in_acc;
  logic              out_free;
  logic              out_load;
  logic              load_err;
  logic              ram_we;
  logic [CODE_W-1:0] code_rd;
  logic [5:0]        len_rd;
  logic              enc_err;
  logic [CODE_W-1:0] code_left;
  logic [ACC_W-1:0]  enc_acc;
  logic [5:0]        enc_total;
  logic [3:0]        pad_len;
  logic [2:0]        pad_val;
  logic [5:0]        fin_total;
  logic [ACC_W-1:0]  fin_acc;

  // Handshake qualifiers
  assign in_stall_o = (st_q != ST_IDLE);
  assign in_acc     = in_valid_i && (st_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Output register loads when the sequencer emits a byte or an error into a free slot
  assign out_load = out_free
                    && ((st_q == ST_ERR) || ((st_q == ST_EMIT) && (total_q >= 6'd8)));

  // Load checks and table write
  assign load_err = ({1'b0, symbol_i} >= SYM_END) || (code_length_i > LEN_LIMIT);
  assign ram_we   = in_acc && (req_type_i == REQ_LOAD) && !load_err;

  hcbp_ram #(
    .WIDTH (CODE_W),
    .DEPTH (SYMBOLS)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (symbol_i[ADDR_W-1:0]),
    .wdata_i (code_bits_i),
    .raddr_i (symbol_i[ADDR_W-1:0]),
    .rdata_o (code_rd)
  );

  hcbp_ram #(
    .WIDTH (6),
    .DEPTH (SYMBOLS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (symbol_i[ADDR_W-1:0]),
    .wdata_i (code_length_i),
    .raddr_i (symbol_i[ADDR_W-1:0]),
    .rdata_o (len_rd)
  );

  // Encode merge: left-align the code, slot it after the pending bits
  assign enc_err = (sym_q == 8'd0) || ({1'b0, sym_q} >= SYM_END)
                   || !vld_q[sym_q[ADDR_W-1:0]] || (len_rd == 6'd0);
  assign code_left = code_rd << (6'd32 - len_rd);
  assign enc_acc   = ({code_left, 7'b0} >> cnt_q) | {pend_q, {CODE_W{1'b0}}};
  assign enc_total = {3'b0, cnt_q} + len_rd;

  // Finish padding: p = 8 - r, or 16 - r when that would be below three
  always_comb begin
    pad_len = 4'd8 - {1'b0, cnt_q};
    if (pad_len < 4'd3) begin
      pad_len = pad_len + 4'd8;
    end
    pad_val   = 3'(pad_len - 4'd3);
    fin_total = {3'b0, cnt_q} + {2'b0, pad_len};
    fin_acc   = {pend_q, {CODE_W{1'b0}}}
                | (ACC_W'(pad_val) << (6'(ACC_W) - fin_total));
  end

  // Sequencer, accumulator and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      acc_q        <= '0;
      total_q      <= '0;
      flag_q       <= 1'b0;
      sym_q        <= '0;
      pend_q       <= '0;
      cnt_q        <= '0;
      vld_q        <= '{default: 1'b0};
      out_valid_q  <= 1'b0;
      out_byte_q   <= '0;
      out_last_q   <= 1'b0;
      out_status_q <= STATUS_OK;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        ST_IDLE: begin
          if (in_acc) begin
            sym_q <= symbol_i;
            case (req_type_i)
              REQ_LOAD: begin
                if (load_err) begin
                  st_q <= ST_ERR;
                end else begin
                  vld_q[symbol_i[ADDR_W-1:0]] <= 1'b1;
                end
              end
              REQ_ENCODE: begin
                st_q <= ST_LOOK;
              end
              REQ_FINISH: begin
                acc_q   <= fin_acc;
                total_q <= fin_total;
                flag_q  <= 1'b1;
                st_q    <= ST_EMIT;
              end
              default: begin
                // unused request code: dropped
              end
            endcase
          end
        end
        ST_LOOK: begin
          if (enc_err) begin
            st_q <= ST_ERR;
          end else begin
            acc_q   <= enc_acc;
            total_q <= enc_total;
            flag_q  <= 1'b0;
            st_q    <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (total_q >= 6'd8) begin
            if (out_free) begin
              out_byte_q   <= acc_q[ACC_W-1 -: 8];
              out_last_q   <= flag_q && (total_q < 6'd16);
              out_status_q <= STATUS_OK;
              acc_q        <= acc_q << 8;
              total_q      <= total_q - 6'd8;
            end
          end else begin
            pend_q <= acc_q[ACC_W-1 -: 7];
            cnt_q  <= total_q[2:0];
            st_q   <= ST_IDLE;
          end
        end
        ST_ERR: begin
          if (out_free) begin
            out_byte_q   <= 8'd0;
            out_last_q   <= 1'b1;
            out_status_q <= STATUS_ERR;
            st_q         <= ST_IDLE;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign is_last_o   = out_last_q;
  assign status_o    = out_status_q;

  // Accumulator never holds more than pending bits plus one code
  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EMIT) |-> (total_q <= 6'(ACC_W)))
    else $error("accumulator bit count out of range");

  // Pending bits beyond the count are always zero between items
  a_pend_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> ((pend_q & (7'h7f >> cnt_q)) == 7'd0))
    else $error("stale bits below the pending count");

  // Error results are flagged last and carry a zero byte
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == STATUS_ERR))
      |-> (out_last_q && (out_byte_q == 8'd0)))
    else $error("malformed error result");

  // Table lookup always resolves to either merging or an error
  a_look_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_LOOK) |=> ((st_q == ST_EMIT) || (st_q == ST_ERR)))
    else $error("lookup did not resolve");

endmodule
`default_nettype wire
